FILE: rtl/core/gha_pkg.sv
package gha_pkg;

    localparam int NUM_BINS_DEF     = 4096;
    localparam int NUM_FEATURES_DEF = 256;

    localparam int BIN_W      = 12;
    localparam int FEAT_W     = 8;
    localparam int VAL_W      = 32;
    localparam int SUM_W      = 64;
    localparam int OFFS_W     = 12;
    localparam int GBIN_W     = 13;
    localparam int ADDR_MAX_W = 16;
    localparam int FIDX_MAX_W = 12;
    localparam int Q_DEPTH    = 2;

    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef enum logic [1:0] {
        CMD_ACCUM = 2'd0,
        CMD_WOFFS = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_SAT   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        K_ACCUM = 2'd0,
        K_CLEAR = 2'd1,
        K_READ  = 2'd2,
        K_FIXED = 2'd3
    } t_kind;

    typedef struct packed {
        t_cmd                     command;
        logic [BIN_W-1:0]         bin_index;
        logic [FEAT_W-1:0]        feature_index;
        logic signed [VAL_W-1:0]  grad_value;
        logic signed [VAL_W-1:0]  hess_value;
        logic [OFFS_W-1:0]        offset_value;
    } t_in_item;

    typedef struct packed {
        logic signed [SUM_W-1:0]  grad_sum;
        logic signed [SUM_W-1:0]  hess_sum;
        t_status                  status;
    } t_out_item;

    typedef struct packed {
        t_kind                    kind;
        logic [ADDR_MAX_W-1:0]    addr;
        logic signed [VAL_W-1:0]  grad;
        logic signed [VAL_W-1:0]  hess;
        t_status                  status;
    } t_op;

endpackage

FILE: rtl/core/gha_queue.sv
module gha_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gha_pkg::t_op  i_push_op,
    output logic          o_ready,
    input  logic          i_pop,
    output logic          o_valid,
    output gha_pkg::t_op  o_op
);

    localparam int PW = (gha_pkg::Q_DEPTH > 1) ? $clog2(gha_pkg::Q_DEPTH) : 1;
    localparam int CW = $clog2(gha_pkg::Q_DEPTH + 1);

    gha_pkg::t_op   r_slot [gha_pkg::Q_DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic [PW-1:0]  n_wr_ptr;
    logic [PW-1:0]  n_rd_ptr;

    assign o_ready = (r_count != CW'(gha_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_slot[r_rd_ptr];

    assign n_wr_ptr = (r_wr_ptr == PW'(gha_pkg::Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PW'(gha_pkg::Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_op;
        end
    end

endmodule

FILE: rtl/core/gha_front.sv
module gha_front #(
    parameter int NUM_BINS     = gha_pkg::NUM_BINS_DEF,
    parameter int NUM_FEATURES = gha_pkg::NUM_FEATURES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  gha_pkg::t_in_item  i_item,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    output logic               o_push,
    output gha_pkg::t_op       o_push_op,
    input  logic               i_q_ready
);

    localparam int FW = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;

    logic [gha_pkg::OFFS_W-1:0]  r_offs [NUM_FEATURES];
    logic [gha_pkg::OFFS_W-1:0]  r_offs_rd;
    logic [FW-1:0]               r_clr_cnt;
    logic                        r_clearing;
    logic                        r_sparse;
    logic                        r_stg_valid;
    gha_pkg::t_in_item           r_stg;

    logic                        w_accept;
    logic [gha_pkg::FIDX_MAX_W-1:0] w_in_feat;
    logic [FW-1:0]               w_in_idx;
    logic                        w_in_feat_ok;
    logic                        w_offs_we;
    logic [FW-1:0]               w_offs_waddr;
    logic [gha_pkg::OFFS_W-1:0]  w_offs_wdata;
    logic                        w_feat_ok;
    logic                        w_bin_ok;
    logic [gha_pkg::GBIN_W-1:0]  w_gbin;
    logic                        w_gbin_ok;

    assign o_busy   = r_clearing || (r_stg_valid && !i_q_ready);
    assign w_accept = i_start && !o_busy;
    assign o_push   = r_stg_valid && i_q_ready;

    assign w_in_feat    = gha_pkg::FIDX_MAX_W'(i_item.feature_index);
    assign w_in_idx     = w_in_feat[FW-1:0];
    assign w_in_feat_ok = (32'(i_item.feature_index) < 32'(NUM_FEATURES));

    assign w_offs_we    = r_clearing ||
                          (w_accept && (i_item.command == gha_pkg::CMD_WOFFS) && w_in_feat_ok);
    assign w_offs_waddr = r_clearing ? r_clr_cnt : w_in_idx;
    assign w_offs_wdata = r_clearing ? '0 : i_item.offset_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_cnt   <= '0;
            r_sparse    <= 1'b0;
            r_stg_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == FW'(NUM_FEATURES - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (i_cfg_we) begin
                r_sparse <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_stg_valid <= 1'b1;
            end else if (o_push) begin
                r_stg_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_offs_we) begin
            r_offs[w_offs_waddr] <= w_offs_wdata;
        end
        if (w_accept) begin
            r_offs_rd <= r_offs[w_in_idx];
            r_stg     <= i_item;
        end
    end

    assign w_feat_ok = (32'(r_stg.feature_index) < 32'(NUM_FEATURES));
    assign w_bin_ok  = (32'(r_stg.bin_index) < 32'(NUM_BINS));
    assign w_gbin    = r_sparse ? gha_pkg::GBIN_W'(r_stg.bin_index)
                                : gha_pkg::GBIN_W'(r_stg.bin_index) +
                                  gha_pkg::GBIN_W'(r_offs_rd);
    assign w_gbin_ok = (32'(w_gbin) < 32'(NUM_BINS));

    always_comb begin
        o_push_op        = '0;
        o_push_op.kind   = gha_pkg::K_FIXED;
        o_push_op.status = gha_pkg::ST_RANGE;
        o_push_op.grad   = r_stg.grad_value;
        o_push_op.hess   = r_stg.hess_value;
        unique case (r_stg.command)
            gha_pkg::CMD_ACCUM: begin
                if ((r_sparse || w_feat_ok) && w_gbin_ok) begin
                    o_push_op.kind   = gha_pkg::K_ACCUM;
                    o_push_op.addr   = gha_pkg::ADDR_MAX_W'(w_gbin);
                    o_push_op.status = gha_pkg::ST_OK;
                end
            end
            gha_pkg::CMD_WOFFS: begin
                if (w_feat_ok) begin
                    o_push_op.status = gha_pkg::ST_OK;
                end
            end
            gha_pkg::CMD_CLEAR: begin
                if (w_bin_ok) begin
                    o_push_op.kind   = gha_pkg::K_CLEAR;
                    o_push_op.addr   = gha_pkg::ADDR_MAX_W'(r_stg.bin_index);
                    o_push_op.status = gha_pkg::ST_OK;
                end
            end
            gha_pkg::CMD_READ: begin
                if (w_bin_ok) begin
                    o_push_op.kind   = gha_pkg::K_READ;
                    o_push_op.addr   = gha_pkg::ADDR_MAX_W'(r_stg.bin_index);
                    o_push_op.status = gha_pkg::ST_OK;
                end
            end
            default: begin
                o_push_op.kind = gha_pkg::K_FIXED;
            end
        endcase
    end

endmodule

FILE: rtl/core/gha_back.sv
module gha_back #(
    parameter int NUM_BINS = gha_pkg::NUM_BINS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  gha_pkg::t_op        i_q_op,
    output logic                o_pop,
    output logic                o_result_valid,
    output gha_pkg::t_out_item  o_result
);

    localparam int BW = $clog2(NUM_BINS);
    localparam int SW = gha_pkg::SUM_W;
    localparam int VW = gha_pkg::VAL_W;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    typedef struct packed {
        logic [SW-1:0] grad;
        logic [SW-1:0] hess;
    } t_bin;

    t_bin                r_mem [NUM_BINS];
    t_bin                r_rdata;
    t_state              r_state;
    logic [BW-1:0]       r_clr_cnt;
    gha_pkg::t_op        r_op;
    logic                r_out_valid;
    gha_pkg::t_out_item  r_out;

    logic                w_we;
    logic [BW-1:0]       w_waddr;
    t_bin                w_wdata;
    logic [SW:0]         w_sum_g;
    logic [SW:0]         w_sum_h;
    logic                w_sat_g;
    logic                w_sat_h;
    logic [SW-1:0]       w_new_g;
    logic [SW-1:0]       w_new_h;
    gha_pkg::t_out_item  w_res;

    assign o_pop          = (r_state == S_IDLE) && i_q_valid;
    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

    assign w_sum_g = {r_rdata.grad[SW-1], r_rdata.grad} +
                     {{(SW+1-VW){r_op.grad[VW-1]}}, r_op.grad};
    assign w_sum_h = {r_rdata.hess[SW-1], r_rdata.hess} +
                     {{(SW+1-VW){r_op.hess[VW-1]}}, r_op.hess};
    assign w_sat_g = w_sum_g[SW] ^ w_sum_g[SW-1];
    assign w_sat_h = w_sum_h[SW] ^ w_sum_h[SW-1];
    assign w_new_g = w_sat_g ? (w_sum_g[SW] ? gha_pkg::SUM_MIN : gha_pkg::SUM_MAX)
                             : w_sum_g[SW-1:0];
    assign w_new_h = w_sat_h ? (w_sum_h[SW] ? gha_pkg::SUM_MIN : gha_pkg::SUM_MAX)
                             : w_sum_h[SW-1:0];

    always_comb begin
        w_res = '0;
        w_we  = 1'b0;
        unique case (r_op.kind)
            gha_pkg::K_ACCUM: begin
                w_res.grad_sum = w_new_g;
                w_res.hess_sum = w_new_h;
                w_res.status   = (w_sat_g || w_sat_h) ? gha_pkg::ST_SAT : gha_pkg::ST_OK;
                w_we           = (r_state == S_EXEC);
            end
            gha_pkg::K_CLEAR: begin
                w_res.status = gha_pkg::ST_OK;
                w_we         = (r_state == S_EXEC);
            end
            gha_pkg::K_READ: begin
                w_res.grad_sum = r_rdata.grad;
                w_res.hess_sum = r_rdata.hess;
                w_res.status   = gha_pkg::ST_OK;
            end
            gha_pkg::K_FIXED: begin
                w_res.status = r_op.status;
            end
            default: begin
                w_res.status = r_op.status;
            end
        endcase
        if (r_state == S_CLEAR) begin
            w_we = 1'b1;
        end
    end

    assign w_waddr = (r_state == S_CLEAR) ? r_clr_cnt : r_op.addr[BW-1:0];
    assign w_wdata = ((r_state == S_CLEAR) || (r_op.kind == gha_pkg::K_CLEAR))
                     ? '0 : {w_new_g, w_new_h};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_cnt <= r_clr_cnt + 1'b1;
                    if (r_clr_cnt == BW'(NUM_BINS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op <= i_q_op;
        end
        if (r_state == S_EXEC) begin
            r_out <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[i_q_op.addr[BW-1:0]];
    end

endmodule

FILE: rtl/core/gradient_histogram_accumulator.sv
// Channel   Ports                               Transfer
// input     i_start, o_busy, i_item             edge with i_start high, o_busy low
// result    o_result_valid, o_result            every edge ending a strobe cycle
// config    i_cfg_we, i_cfg_wdata               every edge with i_cfg_we high
//
// With the queue and bin store idle, a transfer passes the classifier stage register,
// a queue slot, the bin store op register and the result register. The bin store
// pops an item only when idle and finishes its read-modify-write before the next
// pop; a two-entry queue parts the classifier from the bin store.
// After reset the bin store and the offset table are zeroed in parallel, entry by
// entry; o_busy is high until the offsets are done.
// Results never wait: o_busy is high only while the offset table is being cleared,
// or while the classifier holds an item and the queue is full.
module gradient_histogram_accumulator #(
    parameter int NUM_BINS     = gha_pkg::NUM_BINS_DEF,
    parameter int NUM_FEATURES = gha_pkg::NUM_FEATURES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  gha_pkg::t_in_item   i_item,
    output logic                o_result_valid,
    output gha_pkg::t_out_item  o_result,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata
);

    logic          w_push;
    gha_pkg::t_op  w_push_op;
    logic          w_q_ready;
    logic          w_q_valid;
    gha_pkg::t_op  w_q_op;
    logic          w_pop;

    gha_front #(
        .NUM_BINS     (NUM_BINS),
        .NUM_FEATURES (NUM_FEATURES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_push      (w_push),
        .o_push_op   (w_push_op),
        .i_q_ready   (w_q_ready)
    );

    gha_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .i_push_op (w_push_op),
        .o_ready   (w_q_ready),
        .i_pop     (w_pop),
        .o_valid   (w_q_valid),
        .o_op      (w_q_op)
    );

    gha_back #(
        .NUM_BINS (NUM_BINS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_q_valid),
        .i_q_op         (w_q_op),
        .o_pop          (w_pop),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule

FILE: rtl/core/gha_checker.sv
module gha_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                o_busy,
    input  logic                o_result_valid,
    input  gha_pkg::t_out_item  o_result
);

    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe on two consecutive cycles");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_result.status == gha_pkg::ST_OK ||
                            o_result.status == gha_pkg::ST_RANGE ||
                            o_result.status == gha_pkg::ST_SAT))
        else $error("result status code undefined");

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.status == gha_pkg::ST_RANGE) |->
            (o_result.grad_sum == '0 && o_result.hess_sum == '0))
        else $error("ignored item reported non-zero sums");

    a_busy_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> o_busy)
        else $error("transfer possible before clearing pass");

    a_no_result_early: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_result_valid)
        else $error("result strobe straight after reset");

endmodule

bind gradient_histogram_accumulator gha_checker u_gha_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_busy         (o_busy),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);
